FILE: src/hsl_pkg.sv
// shared types and constants for the hsl to rgb pixel pipeline
// fixed point is unsigned with 16 fraction bits, no dependencies
package hsl_pkg;

  localparam int NSTG      = 6;
  localparam int FX_W      = 17;
  localparam int HUE_W     = 9;
  localparam int CH_W      = 8;

  localparam logic [FX_W-1:0] FX_ONE   = 17'h10000;
  localparam logic [FX_W-1:0] FX_HALF  = 17'h08000;
  localparam logic [FX_W-1:0] FX_THIRD = 17'd21845;

  // floor(2^28 / 45), hue * 65536 / 360 == (hue << 13) / 45
  localparam logic [22:0] HUE_RECIP = 23'd5965232;
  localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;
  localparam logic [5:0] HUE_DIV = 6'd45;

  localparam logic [1:0] SEG_RISE = 2'd0;
  localparam logic [1:0] SEG_HIGH = 2'd1;
  localparam logic [1:0] SEG_FALL = 2'd2;
  localparam logic [1:0] SEG_LOW  = 2'd3;

  typedef logic [FX_W-1:0] fx_t;
  typedef logic [NSTG-1:0] hsl_ce_t;

  typedef struct packed {
    fx_t q;
    fx_t p;
    fx_t d;
  } hsl_pq_t;

endpackage

FILE: src/hsl_to_rgb_converter.sv
// top level of the hsl to rgb pixel converter: stream ports, stage valids, stall chain
// depends on hsl_pkg, hsl_prep and hsl_ramp
//
// Converts one pixel per clock, while the output side does not stall, from
// hue (degrees), saturation and lightness to 8-bit red, green and blue. A
// pixel passes three front stages that scale the inputs and form q, p and
// the three ramp positions, and then three stages per channel that pick the
// ramp segment, multiply the slope and scale to 8 bits. Each stage has its
// own valid bit and is loaded whenever it is empty or the stage after it
// moves, so bubbles close up and in_tready stays high as long as the pipeline is not full.
// Zero saturation passes lightness to all three channels.
module hsl_to_rgb_converter import hsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // hue_degrees[8:0], saturation[16:9], lightness[24:17]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  hsl_ce_t          ce;
  logic [NSTG-1:0]  vld_r;
  logic [NSTG-1:0]  gray_r;
  logic [CH_W-1:0]  lit_r [NSTG];

  logic [HUE_W-1:0] hue_in;
  logic [CH_W-1:0]  sat_in, lit_in;

  fx_t              red_t, green_t, blue_t;
  hsl_pq_t          pq;
  logic [CH_W-1:0]  red_c, green_c, blue_c;
  logic [CH_W-1:0]  red, green, blue;

  assign hue_in = in_tdata[8:0];
  assign sat_in = in_tdata[16:9];
  assign lit_in = in_tdata[24:17];

  always_comb begin
    ce[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ce[k] = !vld_r[k] || ce[k+1];
    end
  end

  assign in_tready = ce[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ce[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ce[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      gray_r[0] <= (sat_in == '0);
      lit_r[0]  <= lit_in;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ce[k]) begin
        gray_r[k] <= gray_r[k-1];
        lit_r[k]  <= lit_r[k-1];
      end
    end
  end

  hsl_prep u_prep (
    .clk         (clk),
    .ce          (ce[2:0]),
    .hue_degrees (hue_in),
    .saturation  (sat_in),
    .lightness   (lit_in),
    .red_t_r     (red_t),
    .green_t_r   (green_t),
    .blue_t_r    (blue_t),
    .pq_r        (pq)
  );

  hsl_ramp u_ramp_red (
    .clk    (clk),
    .ce     (ce[5:3]),
    .t      (red_t),
    .pq     (pq),
    .chan_r (red_c)
  );

  hsl_ramp u_ramp_green (
    .clk    (clk),
    .ce     (ce[5:3]),
    .t      (green_t),
    .pq     (pq),
    .chan_r (green_c)
  );

  hsl_ramp u_ramp_blue (
    .clk    (clk),
    .ce     (ce[5:3]),
    .t      (blue_t),
    .pq     (pq),
    .chan_r (blue_c)
  );

  assign red   = gray_r[NSTG-1] ? lit_r[NSTG-1] : red_c;
  assign green = gray_r[NSTG-1] ? lit_r[NSTG-1] : green_c;
  assign blue  = gray_r[NSTG-1] ? lit_r[NSTG-1] : blue_c;

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {blue, green, red};

endmodule

FILE: src/hsl_prep.sv
// front stages: input scaling, q and p forming, hue scaling and ramp positions
// depends on hsl_pkg
module hsl_prep import hsl_pkg::*; (
  input  logic             clk,
  input  logic [2:0]       ce,
  input  logic [HUE_W-1:0] hue_degrees,
  input  logic [CH_W-1:0]  saturation,
  input  logic [CH_W-1:0]  lightness,
  output fx_t              red_t_r,
  output fx_t              green_t_r,
  output fx_t              blue_t_r,
  output hsl_pq_t          pq_r
);

  // stage a
  logic [HUE_W-1:0] hue_m;
  fx_t              s_fx, l_fx;
  logic             lo;
  logic [17:0]      mq_b;
  logic [34:0]      mq_nxt;
  logic [31:0]      hp_nxt;

  logic [HUE_W-1:0] hue_a_r;
  fx_t              s_a_r, l_a_r;
  logic             lo_a_r;
  logic [34:0]      mq_a_r;
  logic [31:0]      hp_a_r;

  assign hue_m  = (hue_degrees >= HUE_WRAP) ? hue_degrees - HUE_WRAP : hue_degrees;
  assign s_fx   = (saturation == 8'hFF) ? FX_ONE : {1'b0, saturation, saturation};
  assign l_fx   = (lightness == 8'hFF) ? FX_ONE : {1'b0, lightness, lightness};
  assign lo     = (l_fx < FX_HALF);
  assign mq_b   = lo ? ({1'b0, FX_ONE} + {1'b0, s_fx}) : {1'b0, s_fx};
  assign mq_nxt = l_fx * mq_b;
  assign hp_nxt = hue_m * HUE_RECIP;

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      hue_a_r <= hue_m;
      s_a_r   <= s_fx;
      l_a_r   <= l_fx;
      lo_a_r  <= lo;
      mq_a_r  <= mq_nxt;
      hp_a_r  <= hp_nxt;
    end
  end

  // stage b
  logic [15:0] qa;
  logic [21:0] hx, r_full;
  logic [18:0] mq_hi, q_raw;
  fx_t         q_c;

  logic [15:0] qa_b_r;
  logic [6:0]  r_b_r;
  fx_t         q_b_r, l_b_r;

  assign qa     = hp_a_r[30:15];
  assign hx     = {hue_a_r, 13'b0};
  assign r_full = hx - ({6'b0, qa} * {16'b0, HUE_DIV});
  assign mq_hi  = mq_a_r[34:16];
  assign q_raw  = lo_a_r ? mq_hi : ({2'b0, l_a_r} + {2'b0, s_a_r} - mq_hi);
  assign q_c    = (q_raw > {2'b0, FX_ONE}) ? FX_ONE : q_raw[16:0];

  always_ff @(posedge clk) begin
    if (ce[1]) begin
      qa_b_r <= qa;
      r_b_r  <= r_full[6:0];
      q_b_r  <= q_c;
      l_b_r  <= l_a_r;
    end
  end

  // stage c
  logic [15:0] h;
  fx_t         t0s, t0, t2;
  logic [17:0] t2s, t2w, twol, pdiff;
  fx_t         p_c, d_c;
  hsl_pq_t     pq_nxt;

  assign h     = qa_b_r + 16'({6'b0, r_b_r} >= {7'b0, HUE_DIV});
  assign t0s   = {1'b0, h} + FX_THIRD;
  assign t0    = (t0s > FX_ONE) ? t0s - FX_ONE : t0s;
  assign t2s   = {2'b0, h} - {1'b0, FX_THIRD};
  assign t2w   = t2s + {1'b0, FX_ONE};
  assign t2    = t2s[17] ? t2w[16:0] : t2s[16:0];
  assign twol  = {l_b_r, 1'b0};
  assign pdiff = twol - {1'b0, q_b_r};
  assign p_c   = ({1'b0, q_b_r} > twol) ? '0 :
                 ((pdiff > {1'b0, FX_ONE}) ? FX_ONE : pdiff[16:0]);
  assign d_c   = (q_b_r > p_c) ? q_b_r - p_c : '0;

  always_comb begin
    pq_nxt.q = q_b_r;
    pq_nxt.p = p_c;
    pq_nxt.d = d_c;
  end

  always_ff @(posedge clk) begin
    if (ce[2]) begin
      red_t_r   <= t0;
      green_t_r <= {1'b0, h};
      blue_t_r  <= t2;
      pq_r      <= pq_nxt;
    end
  end

endmodule

FILE: src/hsl_ramp.sv
// back stages for one color channel: ramp segment, slope product, scale to 8 bits
// depends on hsl_pkg
module hsl_ramp import hsl_pkg::*; (
  input  logic            clk,
  input  logic [2:0]      ce,
  input  fx_t             t,
  input  hsl_pq_t         pq,
  output logic [CH_W-1:0] chan_r
);

  // stage d
  logic [18:0] t6, fall_f;
  logic [1:0]  seg;
  fx_t         f;

  logic [1:0]  seg_d_r;
  fx_t         f_d_r;
  hsl_pq_t     pq_d_r;

  assign t6     = {t, 2'b00} + {1'b0, t, 1'b0};
  assign fall_f = 19'd262144 - t6;

  always_comb begin
    if (t6 < 19'd65536) begin
      seg = SEG_RISE;
    end else if (t6 < 19'd196608) begin
      seg = SEG_HIGH;
    end else if (t6 < 19'd262144) begin
      seg = SEG_FALL;
    end else begin
      seg = SEG_LOW;
    end
    f = (seg == SEG_RISE) ? t6[16:0] : fall_f[16:0];
  end

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      seg_d_r <= seg;
      f_d_r   <= f;
      pq_d_r  <= pq;
    end
  end

  // stage e
  logic [32:0] prod;
  logic [1:0]  seg_e_r;
  fx_t         hi_e_r, p_e_r, q_e_r;

  assign prod = pq_d_r.d * f_d_r;

  always_ff @(posedge clk) begin
    if (ce[1]) begin
      seg_e_r <= seg_d_r;
      hi_e_r  <= prod[32:16];
      p_e_r   <= pq_d_r.p;
      q_e_r   <= pq_d_r.q;
    end
  end

  // stage f
  logic [17:0] v;
  fx_t         v_c;
  logic [24:0] m255;

  always_comb begin
    case (seg_e_r)
      SEG_RISE, SEG_FALL: v = {1'b0, p_e_r} + {1'b0, hi_e_r};
      SEG_HIGH:           v = {1'b0, q_e_r};
      default:            v = {1'b0, p_e_r};
    endcase
  end

  assign v_c  = (v > {1'b0, FX_ONE}) ? FX_ONE : v[16:0];
  assign m255 = {v_c, 8'b0} - {8'b0, v_c};

  always_ff @(posedge clk) begin
    if (ce[2]) begin
      chan_r <= m255[23:16];
    end
  end

endmodule

FILE: src/hsl_chk.sv
// port-level checks for the hsl to rgb converter, bound to the top level
// depends on hsl_to_rgb_converter ports only
module hsl_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // a free output slot lets the whole pipeline move
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tready || !out_tvalid) |-> in_tready)
    else $error("input stalled while output side free");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind hsl_to_rgb_converter hsl_chk u_hsl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
